// ===== hw/rtl/sbea_pkg.sv =====
`timescale 1ns / 1ps

package sbea_pkg;

  // Map geometry: one bit per sector, 64 sectors per map word.
  localparam int unsigned MAP_SECTORS = 16;
  localparam int unsigned MAX_EXTENTS = 64;
  localparam int unsigned MAP_WORDS   = 1024;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned ADDR_W      = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W       = $clog2(WORD_W);
  localparam int unsigned NX_W        = $clog2(MAX_EXTENTS + 1);

  // Allocation starts in the highest word of the scanned region.
  localparam logic [ADDR_W-1:0] SCAN_TOP_WORD = ADDR_W'(MAP_SECTORS * 4096 / WORD_W - 1);

  // Word 0 after reset: sectors 0 to 16 are used.
  localparam logic [WORD_W-1:0] RESET_WORD0 = WORD_W'(64'h1FFFF);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_CLAIM = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FRAG    = 2'd2,
    ST_USED    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AL_RD,
    S_AL_CHK,
    S_AL_BIT,
    S_CL_CHK,
    S_FR_RD,
    S_FR_CHK,
    S_FIN
  } state_e;

  // One access to the map memory: a write when we is set, a read otherwise.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/sbea_map_ram.sv =====
`timescale 1ns / 1ps

module sbea_map_ram (
  input  logic                         clk_i,
  input  sbea_pkg::mem_req_t           req_i,
  output logic [sbea_pkg::WORD_W-1:0]  rdata_o
);

  logic [sbea_pkg::WORD_W-1:0] mem [sbea_pkg::MAP_WORDS];
  logic [sbea_pkg::WORD_W-1:0] rdata_q;

  // Single port: the word read is valid in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end else begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sector_bitmap_extent_allocator.sv =====
`timescale 1ns / 1ps
// A claim reads and updates one map word; a free reads and writes each map word that its
// run touches; an allocation skips full words and tests each word with free sectors bit
// by bit. A stalled result side can hold the scan and the final item.
// Items are taken one at a time; the next is accepted only after the last result loads.
// Reset: rst_ni is asynchronous and active low; then a pass over every map word writes
// the map (sectors 0 to 16 used), and no item is accepted until it is done.
module sector_bitmap_extent_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request side.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sector_count[15:0], sector_index[31:16],
                                      // extent_length[39:32]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  // Result side.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // extent_start[15:0], extent_size[31:16]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast    // last
);

  localparam int unsigned AW = sbea_pkg::ADDR_W;
  localparam int unsigned WW = sbea_pkg::WORD_W;
  localparam int unsigned BW = sbea_pkg::BIT_W;
  localparam int unsigned NW = sbea_pkg::NX_W;

  sbea_pkg::state_e   state_q, state_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [WW-1:0]      word_q, word_d;
  logic [BW-1:0]      bit_q, bit_d;
  logic [15:0]        need_q, need_d;
  logic [NW-1:0]      nx_q, nx_d;
  logic [15:0]        ext_start_q, ext_start_d;
  logic [15:0]        ext_size_q, ext_size_d;
  sbea_pkg::status_e  status_q, status_d;
  logic [16:0]        cur_q, cur_d;
  logic [16:0]        end_q, end_d;

  // Output register.
  logic               out_valid_q;
  logic [31:0]        out_data_q;
  logic [1:0]         out_user_q;
  logic               out_last_q;
  logic               out_free;
  logic               out_load;
  logic [15:0]        out_start;
  logic [15:0]        out_size;
  sbea_pkg::status_e  out_status;
  logic               out_last;

  sbea_pkg::mem_req_t mem_req;
  logic [WW-1:0]      mem_rdata;

  // Input fields.
  logic [15:0]        in_count;
  logic [15:0]        in_index;
  logic [7:0]         in_length;
  logic [16:0]        free_end;
  logic [16:0]        free_sum;

  // Allocation scan helpers.
  logic [16:0]        scan_sector;
  logic               bit_free;
  logic               joins;
  logic               take;
  logic [WW-1:0]      word_nx;

  // Free helpers.
  logic [16:0]        free_last;
  logic [BW-1:0]      free_hi;
  logic [WW-1:0]      free_mask;
  logic [16:0]        next_cur;

  assign in_count  = s_axis_tdata[15:0];
  assign in_index  = s_axis_tdata[31:16];
  assign in_length = s_axis_tdata[39:32];

  // A run that would pass the last sector is cut at the end of the map.
  assign free_sum = {1'b0, in_index} + ((in_length == 8'd0) ? 17'd256 : {9'd0, in_length});
  assign free_end = (free_sum[16] && (free_sum[15:0] != 16'd0)) ? 17'h10000 : free_sum;

  assign scan_sector = {1'b0, addr_q, bit_q};
  assign bit_free    = !word_q[bit_q];
  assign joins       = (nx_q != '0) && ({1'b0, ext_start_q} == (scan_sector + 17'd1));

  // Clear mask for the part of the run that falls into the current word.
  assign free_last = end_q - 17'd1;
  assign free_hi   = (free_last[16:BW] == cur_q[16:BW]) ? free_last[BW-1:0] : {BW{1'b1}};
  assign free_mask = ({WW{1'b1}} << cur_q[BW-1:0]) & ({WW{1'b1}} >> ({BW{1'b1}} - free_hi));
  assign next_cur  = {cur_q[16:BW] + (17 - BW)'(1), {BW{1'b0}}};

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == sbea_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    word_d      = word_q;
    bit_d       = bit_q;
    need_d      = need_q;
    nx_d        = nx_q;
    ext_start_d = ext_start_q;
    ext_size_d  = ext_size_q;
    status_d    = status_q;
    cur_d       = cur_q;
    end_d       = end_q;

    mem_req.we    = 1'b0;
    mem_req.addr  = addr_q;
    mem_req.wdata = word_q;

    out_load   = 1'b0;
    out_start  = ext_start_q;
    out_size   = ext_size_q;
    out_status = sbea_pkg::ST_OK;
    out_last   = 1'b0;

    take    = 1'b0;
    word_nx = word_q;

    unique case (state_q)
      sbea_pkg::S_CLEAR: begin
        // Sweep the whole map once after reset.
        mem_req.we    = 1'b1;
        mem_req.wdata = (addr_q == '0) ? sbea_pkg::RESET_WORD0 : '0;
        addr_d        = addr_q + AW'(1);
        if (addr_q == {AW{1'b1}}) begin
          state_d = sbea_pkg::S_IDLE;
        end
      end

      sbea_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            sbea_pkg::OP_ALLOC: begin
              need_d      = in_count;
              nx_d        = '0;
              ext_start_d = '0;
              ext_size_d  = '0;
              status_d    = sbea_pkg::ST_OK;
              if (in_count == 16'd0) begin
                state_d = sbea_pkg::S_FIN;
              end else begin
                addr_d       = sbea_pkg::SCAN_TOP_WORD;
                mem_req.addr = sbea_pkg::SCAN_TOP_WORD;
                state_d      = sbea_pkg::S_AL_CHK;
              end
            end
            sbea_pkg::OP_CLAIM: begin
              ext_start_d  = in_index;
              addr_d       = in_index[15:BW];
              mem_req.addr = in_index[15:BW];
              state_d      = sbea_pkg::S_CL_CHK;
            end
            sbea_pkg::OP_FREE: begin
              ext_start_d  = in_index;
              ext_size_d   = 16'(free_end - {1'b0, in_index});
              status_d     = sbea_pkg::ST_OK;
              cur_d        = {1'b0, in_index};
              end_d        = free_end;
              addr_d       = in_index[15:BW];
              mem_req.addr = in_index[15:BW];
              state_d      = sbea_pkg::S_FR_CHK;
            end
            default: begin
              // Operation code 3 is dropped without a result.
            end
          endcase
        end
      end

      sbea_pkg::S_AL_RD: begin
        state_d = sbea_pkg::S_AL_CHK;
      end

      sbea_pkg::S_AL_CHK: begin
        if (mem_rdata == {WW{1'b1}}) begin
          // Full word: skip it, reading the next one below straight away.
          if (addr_q == '0) begin
            status_d = sbea_pkg::ST_NOSPACE;
            state_d  = sbea_pkg::S_FIN;
          end else begin
            addr_d       = addr_q - AW'(1);
            mem_req.addr = addr_q - AW'(1);
          end
        end else begin
          word_d  = mem_rdata;
          bit_d   = {BW{1'b1}};
          state_d = sbea_pkg::S_AL_BIT;
        end
      end

      sbea_pkg::S_AL_BIT: begin
        if (!bit_free) begin
          // Used sector: nothing to take.
        end else if (joins) begin
          take        = 1'b1;
          ext_start_d = scan_sector[15:0];
          ext_size_d  = ext_size_q + 16'd1;
        end else if (nx_q >= NW'(sbea_pkg::MAX_EXTENTS)) begin
          // Too many extents: keep the sector free and stop here.
          mem_req.we    = 1'b1;
          mem_req.wdata = word_q;
          status_d      = sbea_pkg::ST_FRAG;
          state_d       = sbea_pkg::S_FIN;
        end else if ((nx_q != '0) && !out_free) begin
          // The finished extent cannot leave yet; hold this sector.
          state_d = sbea_pkg::S_AL_BIT;
        end else begin
          // A new extent opens; the previous one is complete and goes out.
          take        = 1'b1;
          out_load    = (nx_q != '0);
          nx_d        = nx_q + NW'(1);
          ext_start_d = scan_sector[15:0];
          ext_size_d  = 16'd1;
        end

        word_nx = word_q | (take ? (WW'(1) << bit_q) : '0);

        if (state_d == sbea_pkg::S_AL_BIT && !(bit_free && !joins && !take)) begin
          word_d = word_nx;
          need_d = need_q - 16'(take);
          if (take && need_q == 16'd1) begin
            mem_req.we    = 1'b1;
            mem_req.wdata = word_nx;
            status_d      = sbea_pkg::ST_OK;
            state_d       = sbea_pkg::S_FIN;
          end else if (bit_q == '0) begin
            mem_req.we    = 1'b1;
            mem_req.wdata = word_nx;
            if (addr_q == '0) begin
              status_d = sbea_pkg::ST_NOSPACE;
              state_d  = sbea_pkg::S_FIN;
            end else begin
              addr_d  = addr_q - AW'(1);
              state_d = sbea_pkg::S_AL_RD;
            end
          end else begin
            bit_d = bit_q - BW'(1);
          end
        end
      end

      sbea_pkg::S_CL_CHK: begin
        if (mem_rdata[ext_start_q[BW-1:0]]) begin
          ext_size_d = 16'd0;
          status_d   = sbea_pkg::ST_USED;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = mem_rdata | (WW'(1) << ext_start_q[BW-1:0]);
          ext_size_d    = 16'd1;
          status_d      = sbea_pkg::ST_OK;
        end
        state_d = sbea_pkg::S_FIN;
      end

      sbea_pkg::S_FR_RD: begin
        state_d = sbea_pkg::S_FR_CHK;
      end

      sbea_pkg::S_FR_CHK: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata & ~free_mask;
        if (next_cur >= end_q) begin
          state_d = sbea_pkg::S_FIN;
        end else begin
          cur_d   = next_cur;
          addr_d  = next_cur[15:BW];
          state_d = sbea_pkg::S_FR_RD;
        end
      end

      sbea_pkg::S_FIN: begin
        // Final item of the operation, carrying its status.
        if (out_free) begin
          out_load   = 1'b1;
          out_status = status_q;
          out_last   = 1'b1;
          state_d    = sbea_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sbea_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbea_pkg::S_CLEAR;
      addr_q      <= '0;
      need_q      <= '0;
      nx_q        <= '0;
      ext_start_q <= '0;
      ext_size_q  <= '0;
      status_q    <= sbea_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      need_q      <= need_d;
      nx_q        <= nx_d;
      ext_start_q <= ext_start_d;
      ext_size_q  <= ext_size_d;
      status_q    <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    bit_q  <= bit_d;
    cur_q  <= cur_d;
    end_q  <= end_d;
    if (out_load) begin
      out_data_q <= {out_size, out_start};
      out_user_q <= out_status;
      out_last_q <= out_last;
    end
  end

  sbea_map_ram u_map_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== test/sbea_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the allocator, keeps its own copy of the
// sector map, and checks every result item against the oldest prediction.
module sbea_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sector_count[15:0], sector_index[31:16],
                                      // extent_length[39:32]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // extent_start[15:0], extent_size[31:16]
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        m_axis_tlast,   // last
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [15:0] ext_start;
    logic [15:0] ext_size;
    logic [1:0]  ext_status;
    logic        ext_last;
  } extent_result_t;

  logic [sbea_pkg::WORD_W-1:0] sector_map [sbea_pkg::MAP_WORDS];
  extent_result_t              expected_extents [$];
  int unsigned                 mismatches;

  function automatic extent_result_t make_result(input logic [15:0] first,
                                                 input logic [15:0] count,
                                                 input sbea_pkg::status_e st,
                                                 input logic fin);
    extent_result_t r;
    r.ext_start  = first;
    r.ext_size   = count;
    r.ext_status = st;
    r.ext_last   = fin;
    return r;
  endfunction

  // Appends one predicted result item at the back of the queue.
  function automatic void queue_result(input extent_result_t r);
    expected_extents.insert(expected_extents.size(), r);
  endfunction

  // Scan downward from the top of the scanned region, marking free sectors and
  // growing an extent while each new sector sits just below the open one.
  function automatic void predict_allocate(input logic [15:0] count);
    int unsigned       need;
    int unsigned       pos;
    int unsigned       s;
    logic [9:0]        w;
    int unsigned       runs;
    bit                frag;
    logic [15:0]       run_start;
    logic [15:0]       run_size;
    extent_result_t    done_runs [$];
    sbea_pkg::status_e st;
    need      = 32'(count);
    pos       = sbea_pkg::MAP_SECTORS * 4096;
    runs      = 0;
    frag      = 1'b0;
    run_start = '0;
    run_size  = '0;
    if (pos > 65536) pos = 65536;
    while (pos > 0 && need > 0) begin
      s = pos - 1;
      w = 10'(s >> 6);
      if (&sector_map[w]) begin
        pos = 32'(w) << 6;
        continue;
      end
      pos = s;
      if (sector_map[w][6'(s)]) continue;
      if (runs > 0 && 32'(run_start) == s + 1) begin
        run_start = 16'(s);
        run_size  = run_size + 16'd1;
      end else begin
        if (runs >= sbea_pkg::MAX_EXTENTS) begin
          frag = 1'b1;
          break;
        end
        if (runs > 0)
          done_runs.insert(done_runs.size(),
                           make_result(run_start, run_size, sbea_pkg::ST_OK, 1'b0));
        runs++;
        run_start = 16'(s);
        run_size  = 16'd1;
      end
      sector_map[w][6'(s)] = 1'b1;
      need--;
    end
    if (need == 0)  st = sbea_pkg::ST_OK;
    else if (frag)  st = sbea_pkg::ST_FRAG;
    else            st = sbea_pkg::ST_NOSPACE;
    if (runs == 0) begin
      queue_result(make_result('0, '0, st, 1'b1));
    end else begin
      foreach (done_runs[i]) queue_result(done_runs[i]);
      queue_result(make_result(run_start, run_size, st, 1'b1));
    end
  endfunction

  function automatic void predict_claim(input logic [15:0] sector);
    if (sector_map[sector[15:6]][sector[5:0]]) begin
      queue_result(make_result(sector, '0, sbea_pkg::ST_USED, 1'b1));
    end else begin
      sector_map[sector[15:6]][sector[5:0]] = 1'b1;
      queue_result(make_result(sector, 16'd1, sbea_pkg::ST_OK, 1'b1));
    end
  endfunction

  // A run that would pass the last sector is cut there.
  function automatic void predict_free(input logic [15:0] first, input logic [7:0] len);
    int unsigned stop;
    int unsigned s;
    stop = 32'(first) + ((len == 8'd0) ? 256 : 32'(len));
    if (stop > 65536) stop = 65536;
    for (s = 32'(first); s < stop; s++) sector_map[10'(s >> 6)][6'(s)] = 1'b0;
    queue_result(make_result(first, 16'(stop - 32'(first)), sbea_pkg::ST_OK, 1'b1));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    extent_result_t want;
    extent_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < sbea_pkg::MAP_WORDS; i++) sector_map[i] = '0;
      sector_map[0] = sbea_pkg::RESET_WORD0;
      expected_extents.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = make_result(m_axis_tdata[15:0], m_axis_tdata[31:16],
                          sbea_pkg::status_e'(m_axis_tuser), m_axis_tlast);
        if (expected_extents.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing expected: start %0d size %0d status %0d last %0b",
                     got.ext_start, got.ext_size, got.ext_status, got.ext_last);
        end else begin
          want = expected_extents.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected start %0d size %0d status %0d last %0b, %s",
                       want.ext_start, want.ext_size, want.ext_status, want.ext_last,
                       $sformatf("got start %0d size %0d status %0d last %0b",
                                 got.ext_start, got.ext_size, got.ext_status, got.ext_last));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          sbea_pkg::OP_ALLOC: predict_allocate(s_axis_tdata[15:0]);
          sbea_pkg::OP_CLAIM: predict_claim(s_axis_tdata[31:16]);
          sbea_pkg::OP_FREE:  predict_free(s_axis_tdata[31:16], s_axis_tdata[39:32]);
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_extents.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the allocator testbench. It makes the clock, the reset and the request
// items, models the result receiver, and gives the verdict from the checker's
// failure count.
module tb_top;

  // Operation code 3 has no meaning; the block must swallow it silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // The slowest correct run is dominated by one allocation over a free map
  // and a few dozen scans of a mostly full map. The limit is several times that.
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 2000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_request   = 1'b0;
  logic        hold_done      = 1'b0;
  int unsigned hold_left      = 0;
  logic [15:0] last_freed     = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sector_bitmap_extent_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sbea_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Watchdog: a hung handshake or a scan that never ends stops the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result receiver. Normally it stalls at random at the rate of the current
  // phase. Once, when asked, it holds tready low for a long stretch so that the
  // block backs up and stops taking requests while the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one request item and returns at the edge where it is accepted.
  // tvalid is left high, so back-to-back items need only one assignment per
  // edge; a random gap lowers it first.
  task automatic send_item(input logic [1:0] op, input logic [15:0] count,
                           input logic [15:0] index, input logic [7:0] len);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, index, count};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // One random request. Claims often land in or just above the latest freed run so
  // that both the free and the already-used outcome keep turning up. Most
  // allocations are small; an occasional full-range count sweeps the map and
  // may end on not enough space or on too many fragments.
  task automatic send_random_item();
    int unsigned pick;
    logic [15:0] idx;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom));
    end else if (pick < 35) begin
      idx        = 16'($urandom);
      last_freed = idx;
      send_item(sbea_pkg::OP_FREE, 16'($urandom), idx, 8'($urandom));
    end else if (pick < 60) begin
      if ($urandom_range(1) == 1) idx = last_freed + 16'($urandom_range(0, 255));
      else                        idx = 16'($urandom);
      send_item(sbea_pkg::OP_CLAIM, 16'($urandom), idx, 8'($urandom));
    end else if ($urandom_range(9) == 0) begin
      send_item(sbea_pkg::OP_ALLOC, 16'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      send_item(sbea_pkg::OP_ALLOC, 16'($urandom_range(0, 40)), 16'($urandom),
                8'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, no idling on either side. The block runs its map clearing
    // pass first; the handshake simply waits for it.
    send_item(sbea_pkg::OP_ALLOC, 16'd0, 16'd0, 8'd0);     // zero count: ok, no extent
    send_item(sbea_pkg::OP_CLAIM, 16'd0, 16'd0, 8'd0);     // reserved sectors are used
    send_item(sbea_pkg::OP_CLAIM, 16'd0, 16'd16, 8'd0);
    send_item(sbea_pkg::OP_CLAIM, 16'd0, 16'd17, 8'd0);    // first free sector
    send_item(sbea_pkg::OP_CLAIM, 16'd0, 16'hFFFF, 8'd0);  // last sector, free then used
    send_item(sbea_pkg::OP_CLAIM, 16'd0, 16'hFFFF, 8'd0);
    send_item(sbea_pkg::OP_ALLOC, 16'd1, 16'd0, 8'd0);
    send_item(sbea_pkg::OP_ALLOC, 16'd5, 16'd0, 8'd0);
    // A free inside one map word must leave the rest of that word alone.
    send_item(sbea_pkg::OP_FREE, 16'd0, 16'd65530, 8'd2);
    // The two freed sectors merge into one extent, then a new one opens below.
    send_item(sbea_pkg::OP_ALLOC, 16'd3, 16'd0, 8'd0);
    // A 256-sector free that runs past the last sector is cut there.
    send_item(sbea_pkg::OP_FREE, 16'd0, 16'd65500, 8'd0);
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(sbea_pkg::OP_FREE, 16'd0, 16'd0, 8'd255);
    send_item(sbea_pkg::OP_FREE, 16'd0, 16'd0, 8'd0);
    // The map is now wholly free: one long extent covers all but sector 0.
    send_item(sbea_pkg::OP_ALLOC, 16'hFFFF, 16'd0, 8'd0);
    send_item(sbea_pkg::OP_ALLOC, 16'd1, 16'd0, 8'd0);
    // Full map: a status-only result reporting not enough space.
    send_item(sbea_pkg::OP_ALLOC, 16'd1, 16'd0, 8'd0);
    // Two separate holes are found, then space runs out on the final extent.
    send_item(sbea_pkg::OP_FREE, 16'd0, 16'd300, 8'd1);
    send_item(sbea_pkg::OP_FREE, 16'd0, 16'd302, 8'd1);
    send_item(sbea_pkg::OP_ALLOC, 16'd5, 16'd0, 8'd0);
    send_item(sbea_pkg::OP_FREE, 16'd0, 16'd1000, 8'h80);
    send_item(sbea_pkg::OP_FREE, 16'd0, 16'd40000, 8'h7F);
    send_item(sbea_pkg::OP_CLAIM, 16'd0, 16'd40010, 8'd0);
    send_item(sbea_pkg::OP_CLAIM, 16'd0, 16'd40010, 8'd0);
    send_item(sbea_pkg::OP_ALLOC, 16'd200, 16'd0, 8'd0);

    // Fragmentation sequence with an idle sender: punch about seventy
    // separate holes into the nearly full map, then ask for everything. The
    // allocation has to stop at the extent limit and flag too many fragments.
    send_idle_pct = 47;
    for (k = 0; k < 70; k++)
      send_item(sbea_pkg::OP_FREE, 16'($urandom), 16'(k * 900 + $urandom_range(17, 400)),
                8'($urandom_range(1, 8)));
    send_item(sbea_pkg::OP_ALLOC, 16'hFFFF, 16'($urandom), 8'($urandom));

    // Receiver stalls. The long hold-off starts here while a burst of claims is
    // offered back to back, so the block fills up and blocks its input.
    send_idle_pct = 0;
    recv_stall_pct <= 47;
    hold_request   <= 1'b1;
    for (k = 0; k < 10; k++)
      send_item(sbea_pkg::OP_CLAIM, 16'($urandom), 16'($urandom), 8'($urandom));
    for (k = 0; k < 15; k++) send_random_item();

    // Both sides idle.
    send_idle_pct = 37;
    recv_stall_pct <= 37;
    for (k = 0; k < 20; k++) send_random_item();
    s_axis_tvalid <= 1'b0;

    // Drain: every expectation must be met, then a short quiet tail lets any
    // stray result item show up.
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
